FILE: design/pst_pkg.sv
// pst_pkg: payload structs and controller/datapath interface types for pair_sum_match_table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pst_pkg;

  localparam int VALUE_BITS     = 32;
  localparam int INDEX_OUT_BITS = 16;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value_in;
    logic                         is_last;
  } in_t;

  typedef struct packed {
    logic                      hit;
    logic                      answer_valid;
    logic [INDEX_OUT_BITS-1:0] first_index;
    logic [INDEX_OUT_BITS-1:0] second_index;
    logic                      table_overflow;
    logic                      done_res;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // latch the accepted item
    logic scan_en;  // walk the table
    logic finish;   // commit insert/answer and load the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;  // table walk complete, match flags final
    logic out_free;   // output register can take a result this cycle
  } status_t;

endpackage

`default_nettype wire

FILE: design/pst_ctrl.sv
// pst_ctrl: sequencing state machine for pair_sum_match_table
// depends on pst_pkg
`timescale 1ns / 1ps
`default_nettype none

module pst_ctrl
  import pst_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  state_t state;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd.load    = (state == ST_IDLE) && in_valid;
    cmd.scan_en = (state == ST_SCAN);
    cmd.finish  = (state == ST_COMMIT) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (status.scan_done) state <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (status.out_free) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/pst_datapath.sv
// pst_datapath: value/index table memory, sequential match scan, answer and output registers
// depends on pst_pkg
`timescale 1ns / 1ps
`default_nettype none

module pst_datapath
  import pst_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int INDEX_BITS  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [VALUE_BITS-1:0] cfg_wr_data,
  input  wire in_t                   in_data,
  input  wire cmd_t                  cmd,
  output status_t                    status,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_t                       out_data
);

  localparam int ADDR_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [ADDR_BITS:0] DEPTH_CNT = (ADDR_BITS + 1)'(TABLE_DEPTH);

  // table storage, no reset: entries below fill are the only ones read
  logic [VALUE_BITS-1:0] mem_value [TABLE_DEPTH];
  logic [INDEX_BITS-1:0] mem_index [TABLE_DEPTH];

  logic signed [VALUE_BITS-1:0] target_sum;
  logic [ADDR_BITS:0]           fill;
  logic [INDEX_BITS-1:0]        count;
  logic                         ans_valid;
  logic [INDEX_BITS-1:0]        ans_first;
  logic [INDEX_BITS-1:0]        ans_second;
  logic                         overflow;

  logic [VALUE_BITS-1:0]        item_value;
  logic                         item_last;
  logic signed [VALUE_BITS:0]   need;

  logic [ADDR_BITS:0]           rd_ptr;
  logic                         rd_pending;
  logic [VALUE_BITS-1:0]        rd_value;
  logic [INDEX_BITS-1:0]        rd_index;
  logic                         match_hit;
  logic                         match_dup;
  logic [INDEX_BITS-1:0]        match_index;

  logic                         issue;
  logic                         cmp_hit;
  logic                         cmp_dup;
  logic                         do_insert;
  logic                         ans_valid_next;
  logic [INDEX_BITS-1:0]        ans_first_next;
  logic [INDEX_BITS-1:0]        ans_second_next;
  logic                         overflow_next;

  assign issue   = cmd.scan_en && !match_hit && (rd_ptr < fill);
  assign cmp_hit = rd_pending && !match_hit &&
                   ($signed({rd_value[VALUE_BITS-1], rd_value}) == need);
  assign cmp_dup = rd_pending && (rd_value == item_value);

  assign status.scan_done = !rd_pending && (match_hit || (rd_ptr >= fill));
  assign status.out_free  = !out_valid || !out_stall;

  assign do_insert = !match_hit && !match_dup && (fill < DEPTH_CNT);

  always_comb begin
    ans_valid_next  = ans_valid;
    ans_first_next  = ans_first;
    ans_second_next = ans_second;
    overflow_next   = overflow;
    if (match_hit) begin
      ans_valid_next  = 1'b1;
      ans_first_next  = match_index;
      ans_second_next = count;
    end else if (!match_dup && (fill >= DEPTH_CNT)) begin
      overflow_next = 1'b1;
    end
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.finish && do_insert) begin
      mem_value[fill[ADDR_BITS-1:0]] <= item_value;
      mem_index[fill[ADDR_BITS-1:0]] <= count;
    end
    if (issue) begin
      rd_value <= mem_value[rd_ptr[ADDR_BITS-1:0]];
      rd_index <= mem_index[rd_ptr[ADDR_BITS-1:0]];
    end
  end

  // item latch and difference, match index capture and output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_value <= in_data.value_in;
      item_last  <= in_data.is_last;
      need       <= $signed({target_sum[VALUE_BITS-1], target_sum})
                  - $signed({in_data.value_in[VALUE_BITS-1], in_data.value_in});
    end
    if (cmp_hit) match_index <= rd_index;
    if (cmd.finish) begin
      out_data.hit            <= match_hit;
      out_data.answer_valid   <= ans_valid_next;
      out_data.first_index    <= INDEX_OUT_BITS'(ans_first_next);
      out_data.second_index   <= INDEX_OUT_BITS'(ans_second_next);
      out_data.table_overflow <= overflow_next;
      out_data.done_res       <= item_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= '0;
      fill       <= '0;
      count      <= '0;
      ans_valid  <= 1'b0;
      ans_first  <= '0;
      ans_second <= '0;
      overflow   <= 1'b0;
      rd_ptr     <= '0;
      rd_pending <= 1'b0;
      match_hit  <= 1'b0;
      match_dup  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) target_sum <= cfg_wr_data;

      if (cmd.load) begin
        rd_ptr     <= '0;
        rd_pending <= 1'b0;
        match_hit  <= 1'b0;
        match_dup  <= 1'b0;
      end else begin
        rd_pending <= issue;
        if (issue) rd_ptr <= rd_ptr + 1'b1;
        if (cmp_hit) match_hit <= 1'b1;
        if (cmp_dup) match_dup <= 1'b1;
      end

      if (cmd.finish) begin
        if (item_last) begin
          fill       <= '0;
          count      <= '0;
          ans_valid  <= 1'b0;
          ans_first  <= '0;
          ans_second <= '0;
          overflow   <= 1'b0;
        end else begin
          if (do_insert) fill <= fill + 1'b1;
          count      <= count + 1'b1;
          ans_valid  <= ans_valid_next;
          ans_first  <= ans_first_next;
          ans_second <= ans_second_next;
          overflow   <= overflow_next;
        end
      end

      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/pair_sum_match_table.sv
// pair_sum_match_table: two-sum search over a streamed array with a value/index table
// depends on pst_pkg, pst_ctrl, pst_datapath
`timescale 1ns / 1ps
`default_nettype none

//  channel   direction  handshake              payload
//  in        input      in_valid / in_stall    in_data (in_t: value_in, is_last)
//  out       output     out_valid / out_stall  out_data (out_t: hit .. done_res)
//  cfg       input      cfg_wr_en              cfg_wr_data (target_sum)
//
//  after an input transfer the scan reads the stored entries, the result is then
//  committed into the output register, and only then is the next input taken;
//  with an empty table no entry is read before the commit
//  the table memory has one read port, so the scan reads one entry per cycle;
//  it reads every stored entry, or stops one entry past the first match
//  reset is synchronous; the table needs no clearing pass, a fill count marks
//  the valid entries and the last element of an array just zeroes it
//  the next element is taken while a result still waits in the output register;
//  only its commit waits for out_stall to drop
module pair_sum_match_table
  import pst_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int INDEX_BITS  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [VALUE_BITS-1:0] cfg_wr_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_t                       out_data
);

  cmd_t    cmd;
  status_t status;

  // sequencing: idle, table scan, commit
  pst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // table memory, match compare, answer state and output register
  pst_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .INDEX_BITS  (INDEX_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  // an accepted element keeps the input stalled while it is worked on
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a transfer");

  // a commit never overwrites a result that is still waiting
  assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || !out_stall))
    else $error("commit while output register is blocked");

  // a new result shows up only after a commit
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("output valid without a commit");

  // commit only after the scan has finished
  assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> status.scan_done)
    else $error("commit before scan completed");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// testbench: streams arrays into pair_sum_match_table and checks every result against
// an in-bench model of the value/index table; depends on pst_pkg and the rtl top level
`timescale 1ns / 1ps

module testbench
  import pst_pkg::*;
();

  localparam int DEPTH       = 64;  // table entries, matches the rtl default
  localparam int IDX_W       = 16;  // element counter width, matches the rtl default
  localparam int PHASE_ITEMS = 145; // random elements per idling phase
  localparam int PHASES      = 10;

  // one directed stimulus row: optional new target before it, optional typed result
  typedef struct {
    logic signed [31:0] value;
    bit                 last;
    bit                 retarget;
    logic signed [31:0] target;
    bit                 typed;
    out_t               result;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [VALUE_BITS-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  always #2 clk = ~clk;

  pair_sum_match_table uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // idling knobs, in percent of cycles
  int idle_pct  = 0;
  int stall_pct = 0;

  // bookkeeping
  int fails        = 0;
  int elems_in     = 0;
  int results_out  = 0;
  int pair_hits    = 0;
  int ovf_arrays   = 0;
  int target_wrs   = 0;
  int rand_elems   = 0;
  logic signed [31:0] cur_target = '0;

  // ---------------------------------------------------------------------------
  // table model: the bench's own copy of target, stored pairs and answer
  // ---------------------------------------------------------------------------
  logic signed [31:0] target_q;
  logic signed [31:0] tbl_value [DEPTH];
  logic [IDX_W-1:0]   tbl_index [DEPTH];
  bit                 tbl_used  [DEPTH];
  logic [IDX_W-1:0]   next_idx;
  bit                 ans_ok;
  logic [IDX_W-1:0]   ans_first;
  logic [IDX_W-1:0]   ans_second;
  bit                 ovf_seen;

  // results still owed by the block, oldest first
  out_t pending_results [$];
  // a typed result for the element being offered, used instead of the model's
  bit   typed_pending = 1'b0;
  out_t typed_result  = '0;

  function automatic void clear_table();
    foreach (tbl_used[i]) tbl_used[i] = 1'b0;
    next_idx   = '0;
    ans_ok     = 1'b0;
    ans_first  = '0;
    ans_second = '0;
    ovf_seen   = 1'b0;
  endfunction

  // one element through the table: lookup of target - value at full width,
  // insert on a miss unless the value is already held
  function automatic out_t pair_lookup(in_t item);
    longint need;
    bit     hit;
    bit     dup;
    int     free_slot;
    out_t   r;
    need      = longint'(target_q) - longint'(item.value_in);
    hit       = 1'b0;
    dup       = 1'b0;
    free_slot = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (tbl_used[i]) begin
        if (!hit && longint'(tbl_value[i]) == need) begin
          hit        = 1'b1;
          ans_ok     = 1'b1;
          ans_first  = tbl_index[i];
          ans_second = next_idx;
        end
        if (tbl_value[i] == item.value_in) dup = 1'b1;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    // a hit never inserts; a duplicate is skipped without any flag
    if (!hit && !dup) begin
      if (free_slot >= 0) begin
        tbl_value[free_slot] = item.value_in;
        tbl_index[free_slot] = next_idx;
        tbl_used[free_slot]  = 1'b1;
      end else begin
        ovf_seen = 1'b1;
      end
    end
    next_idx         = next_idx + 1'b1;  // wraps at the counter width
    r.hit            = hit;
    r.answer_valid   = ans_ok;
    r.first_index    = ans_ok ? ans_first : '0;
    r.second_index   = ans_ok ? ans_second : '0;
    r.table_overflow = ovf_seen;
    r.done_res       = item.is_last;
    // the last element ends the array and empties everything for the next one
    if (item.is_last) clear_table();
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fails++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: everything is sampled at the rising edge, before the block updates
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_t predicted;
    out_t want;
    if (!rst) begin
      if (cfg_wr_en) target_q = cfg_wr_data;
      // accepted input transfer: run the model, queue what the block owes
      if (in_valid && !in_stall) begin
        predicted = pair_lookup(in_data);
        if (typed_pending) begin
          predicted     = typed_result;
          typed_pending = 1'b0;
        end
        pending_results = {pending_results, predicted};
        elems_in++;
      end
      // accepted output transfer: compare with the oldest expectation
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          fails++;
          $error("result transfer with nothing expected");
        end else begin
          want = pending_results.pop_front();
          check_field("hit", want.hit, out_data.hit);
          check_field("answer_valid", want.answer_valid, out_data.answer_valid);
          check_field("first_index", want.first_index, out_data.first_index);
          check_field("second_index", want.second_index, out_data.second_index);
          check_field("table_overflow", want.table_overflow, out_data.table_overflow);
          check_field("done_res", want.done_res, out_data.done_res);
          results_out++;
          if (out_data.hit) pair_hits++;
          if (out_data.done_res && out_data.table_overflow) ovf_arrays++;
        end
      end
    end
  end

  // receiver: random stall, changed only at the falling edge
  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offer one element; idle gaps are decided before valid rises, so valid
  // never depends on stall, and the payload holds until the transfer
  task automatic push_elem(in_t item, bit typed, out_t result);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    typed_pending = typed;
    typed_result  = result;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending and wait until every owed result has come out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // the target may only change while the block has nothing in flight
  task automatic set_target(logic signed [31:0] t);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= t;
    @(negedge clk);
    cfg_wr_en  <= 1'b0;
    cur_target  = t;
    target_wrs++;
  endtask

  function automatic logic signed [31:0] corner_value(int sel);
    case (sel)
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return -32'sd1;
      default: return '0;
    endcase
  endfunction

  function automatic stim_row_t dir_row(logic signed [31:0] value, bit last, bit retarget,
                                        logic signed [31:0] target, bit typed, out_t result);
    stim_row_t r;
    r.value    = value;
    r.last     = last;
    r.retarget = retarget;
    r.target   = target;
    r.typed    = typed;
    r.result   = result;
    return r;
  endfunction

  function automatic out_t mk_result(bit hit, bit av, int first, int second, bit ovf, bit done);
    out_t r;
    r.hit            = hit;
    r.answer_valid   = av;
    r.first_index    = first[IDX_W-1:0];
    r.second_index   = second[IDX_W-1:0];
    r.table_overflow = ovf;
    r.done_res       = done;
    return r;
  endfunction

  // one random array: mostly values from a small pool and their complements so
  // pairs and duplicates are common; wide arrays are mostly fresh values and
  // run the table full
  task automatic random_array(bit wide);
    logic signed [31:0] pool [6];
    int   len;
    int   pick;
    in_t  item;
    len = wide ? $urandom_range(80, 66) : $urandom_range(16, 1);
    foreach (pool[k]) begin
      pool[k] = $urandom();
      if ($urandom_range(3) == 0) pool[k] = corner_value($urandom_range(3));
    end
    for (int n = 0; n < len; n++) begin
      pick = $urandom_range(99);
      if (wide ? (pick < 85) : (pick >= 75)) item.value_in = $urandom();
      else if (pick < 40 || wide) item.value_in = pool[$urandom_range(5)];
      else item.value_in = cur_target - pool[$urandom_range(5)];
      item.is_last = (n == len - 1);
      // now and then the sender holds off until the block is empty
      if ($urandom_range(39) == 0) drain();
      push_elem(item, 1'b0, '0);
      rand_elems++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t dir_rows [20];
    in_t       item;
    int        wide_pick;

    clear_table();
    target_q = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed part: extremes of value and target, out of range differences,
    // duplicates, answer overwrite; typed results only where obvious
    dir_rows = '{
      // target 0 after reset: a zero pair
      dir_row(32'sd0, 1'b0, 1'b0, '0, 1'b1, mk_result(0, 0, 0, 0, 0, 0)),
      dir_row(32'sd0, 1'b1, 1'b0, '0, 1'b1, mk_result(1, 1, 0, 1, 0, 1)),
      // difference out of 32-bit range, then a duplicate, then max + (min+1)
      dir_row(32'sh8000_0000, 1'b0, 1'b0, '0, 1'b1, mk_result(0, 0, 0, 0, 0, 0)),
      dir_row(32'sh7fff_ffff, 1'b0, 1'b0, '0, 1'b1, mk_result(0, 0, 0, 0, 0, 0)),
      dir_row(32'sh8000_0000, 1'b0, 1'b0, '0, 1'b1, mk_result(0, 0, 0, 0, 0, 0)),
      dir_row(32'sh8000_0001, 1'b1, 1'b0, '0, 1'b1, mk_result(1, 1, 1, 3, 0, 1)),
      // largest target
      dir_row(-32'sd1, 1'b0, 1'b1, 32'sh7fff_ffff, 1'b0, '0),
      dir_row(32'sd0, 1'b0, 1'b0, '0, 1'b0, '0),
      dir_row(32'sh7fff_ffff, 1'b0, 1'b0, '0, 1'b0, '0),
      dir_row(32'sh5555_5555, 1'b0, 1'b0, '0, 1'b0, '0),
      dir_row(32'sh2aaa_aaaa, 1'b1, 1'b0, '0, 1'b0, '0),
      // smallest target
      dir_row(32'sd1, 1'b0, 1'b1, 32'sh8000_0000, 1'b0, '0),
      dir_row(32'sd0, 1'b0, 1'b0, '0, 1'b0, '0),
      dir_row(32'sh8000_0000, 1'b0, 1'b0, '0, 1'b0, '0),
      dir_row(-32'sd1, 1'b0, 1'b0, '0, 1'b0, '0),
      dir_row(32'shaaaa_aaaa, 1'b1, 1'b0, '0, 1'b0, '0),
      // target -1: a second pair replaces the first answer
      dir_row(32'sd3, 1'b0, 1'b1, -32'sd1, 1'b0, '0),
      dir_row(32'sd0, 1'b0, 1'b0, '0, 1'b0, '0),
      dir_row(-32'sd4, 1'b0, 1'b0, '0, 1'b0, '0),
      dir_row(-32'sd1, 1'b1, 1'b0, '0, 1'b0, '0)
    };
    foreach (dir_rows[r]) begin
      if (dir_rows[r].retarget) set_target(dir_rows[r].target);
      item.value_in = dir_rows[r].value;
      item.is_last  = dir_rows[r].last;
      push_elem(item, dir_rows[r].typed, dir_rows[r].result);
    end

    // random part: phases cycle through no idling, sender idle, receiver
    // stalling and both; the first phases use the corner targets
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 87; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 87; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      set_target(phase < 4 ? corner_value(phase) : $urandom());
      while (rand_elems < (phase + 1) * PHASE_ITEMS) begin
        wide_pick = $urandom_range(7);
        random_array(wide_pick == 0);
      end
    end

    drain();
    repeat (80) @(posedge clk);
    if (pending_results.size() != 0) begin
      fails++;
      $error("%0d results never arrived", pending_results.size());
    end

    $display("run covered %0d elements and %0d results: %0d pair hits, %0d arrays overflowed",
             elems_in, results_out, pair_hits, ovf_arrays);
    $display("target written %0d times, idling varied over %0d phases",
             target_wrs, PHASES);
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: filelist.f
design/pst_pkg.sv
design/pst_ctrl.sv
design/pst_datapath.sv
design/pair_sum_match_table.sv
bench/testbench.sv
